// File: hw/rtl/mips_pkg.sv
// ============================================================================
// MIPS integer execute package
// Shared opcode and function codes, result types and the reset address.
// ============================================================================
package mips_pkg;

    localparam logic [31:0] RESET_ADDR_DEFAULT = 32'hBFC0_0000;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;

    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MOVZ  = 6'h0A;
    localparam logic [5:0] FN_MOVN  = 6'h0B;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLTU  = 6'h2B;
    localparam logic [5:0] FN2_MUL  = 6'h02;

    localparam logic [4:0] LINK_REG = 5'd31;

    // Packed result item, first field highest.
    typedef struct packed {
        logic        unsupported;
        logic        nullified;
        logic [31:0] next_address;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write;
        logic [31:0] instr_address;
    } t_result;

    // Architectural update produced by the execute logic.
    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_idx;
        logic [31:0] rf_val;
        logic        hilo_we;
        logic [31:0] hi_val;
        logic [31:0] lo_val;
        logic        state_we;
        logic        br_pending;
        logic [31:0] br_target;
        logic        cancel;
        logic [31:0] next_pc;
    } t_update;

endpackage

// File: hw/rtl/mips_regfile.sv
// ============================================================================
// MIPS register file
// 31 general registers in flip-flops with two read ports; register 0 reads
// zero. Reset clears every entry.
// ============================================================================
module mips_regfile
    import mips_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_rs,
    input  logic [4:0]  i_rt,
    output logic [31:0] o_vs,
    output logic [31:0] o_vt,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd
);
    logic [31:0] r_regs [32];

    // Write port; entry 0 is never written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_regs[i] <= '0;
        end else if (i_we && i_wa != 5'd0) begin
            r_regs[i_wa] <= i_wd;
        end
    end

    // Read ports.
    assign o_vs = (i_rs == 5'd0) ? 32'd0 : r_regs[i_rs];
    assign o_vt = (i_rt == 5'd0) ? 32'd0 : r_regs[i_rt];
endmodule

// File: hw/rtl/mips_exec.sv
// ============================================================================
// MIPS execute logic
// Decodes one instruction against the current state and forms the result
// item and the architectural update.
// ============================================================================
module mips_exec
    import mips_pkg::*;
(
    input  logic [31:0] i_word,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_vs,
    input  logic [31:0] i_vt,
    input  logic [31:0] i_hi,
    input  logic [31:0] i_lo,
    input  logic        i_br_pending,
    input  logic [31:0] i_br_target,
    input  logic        i_cancel,
    output t_result     o_res,
    output t_update     o_upd
);
    logic [5:0]  opc, fn;
    logic [4:0]  rd, rt, sa;
    logic [15:0] imm;
    logic [31:0] simm, btarget, jtarget, pc4, pc8, nxt;
    logic [63:0] prod_s, prod_u;
    logic        ok, wr, isbr, cond, likely, jump, wr_eff;
    logic [4:0]  widx;
    logic [31:0] wval;

    assign opc  = i_word[31:26];
    assign rt   = i_word[20:16];
    assign rd   = i_word[15:11];
    assign sa   = i_word[10:6];
    assign fn   = i_word[5:0];
    assign imm  = i_word[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign pc4  = i_pc + 32'd4;
    assign pc8  = i_pc + 32'd8;
    assign btarget = pc4 + {simm[29:0], 2'b00};
    assign jtarget = {pc4[31:28], i_word[25:0], 2'b00};
    assign prod_s  = $signed(i_vs) * $signed(i_vt);
    assign prod_u  = i_vs * i_vt;

    // Instruction decode.
    always_comb begin
        ok = 1'b1; wr = 1'b0; isbr = 1'b0; cond = 1'b0; likely = 1'b0;
        jump = 1'b0; widx = '0; wval = '0;
        if (!i_cancel) begin
            unique case (opc)
                OP_SPECIAL: begin
                    widx = rd;
                    unique case (fn)
                        FN_SLL:  begin wr = 1'b1; wval = i_vt << sa; end
                        FN_JR:   jump = 1'b1;
                        FN_MOVZ: begin wr = (i_vt == 32'd0); wval = i_vs; end
                        FN_MOVN: begin wr = (i_vt != 32'd0); wval = i_vs; end
                        FN_MFHI: begin wr = 1'b1; wval = i_hi; end
                        FN_MFLO: begin wr = 1'b1; wval = i_lo; end
                        FN_MULT, FN_MULTU: ;
                        FN_ADD, FN_ADDU: begin wr = 1'b1; wval = i_vs + i_vt; end
                        FN_AND:  begin wr = 1'b1; wval = i_vs & i_vt; end
                        FN_OR:   begin wr = 1'b1; wval = i_vs | i_vt; end
                        FN_XOR:  begin wr = 1'b1; wval = i_vs ^ i_vt; end
                        FN_NOR:  begin wr = 1'b1; wval = ~(i_vs | i_vt); end
                        FN_SLTU: begin wr = 1'b1; wval = {31'd0, i_vs < i_vt}; end
                        default: ok = 1'b0;
                    endcase
                end
                OP_REGIMM: begin
                    if (rt[3:2] != 2'b00 || (!rt[4] && rt > 5'd3)) begin
                        ok = 1'b0;
                    end else begin
                        isbr   = 1'b1;
                        likely = rt[1];
                        cond   = rt[0] ? !i_vs[31] : i_vs[31];
                        if (rt[4]) begin
                            wr = 1'b1; widx = LINK_REG; wval = pc8;
                        end
                    end
                end
                OP_J:   jump = 1'b1;
                OP_JAL: begin jump = 1'b1; wr = 1'b1; widx = LINK_REG; wval = pc8; end
                OP_BEQ, OP_BEQL: begin isbr = 1'b1; cond = (i_vs == i_vt); end
                OP_BNE, OP_BNEL: begin isbr = 1'b1; cond = (i_vs != i_vt); end
                OP_BLEZ, OP_BLEZL: begin
                    isbr = 1'b1; cond = i_vs[31] || (i_vs == 32'd0);
                end
                OP_BGTZ, OP_BGTZL: begin
                    isbr = 1'b1; cond = !i_vs[31] && (i_vs != 32'd0);
                end
                OP_ADDI, OP_ADDIU: begin wr = 1'b1; widx = rt; wval = i_vs + simm; end
                OP_ANDI: begin wr = 1'b1; widx = rt; wval = i_vs & {16'd0, imm}; end
                OP_ORI:  begin wr = 1'b1; widx = rt; wval = i_vs | {16'd0, imm}; end
                OP_XORI: begin wr = 1'b1; widx = rt; wval = i_vs ^ {16'd0, imm}; end
                OP_LUI:  begin wr = 1'b1; widx = rt; wval = {imm, 16'd0}; end
                OP_SPECIAL2: begin
                    if (fn == FN2_MUL) begin
                        wr = 1'b1; widx = rd; wval = prod_s[31:0];
                    end else begin
                        ok = 1'b0;
                    end
                end
                default: ok = 1'b0;
            endcase
            if (opc == OP_BEQL || opc == OP_BNEL || opc == OP_BLEZL || opc == OP_BGTZL)
                likely = 1'b1;
        end
    end

    assign wr_eff = wr && (widx != 5'd0);
    assign nxt    = i_br_pending ? i_br_target : pc4;

    // Result item and state update.
    always_comb begin
        o_res.instr_address = i_pc;
        o_res.unsupported   = !ok;
        o_res.nullified     = ok && i_cancel;
        o_res.reg_write     = ok && wr_eff;
        o_res.reg_index     = (ok && wr_eff) ? widx : 5'd0;
        o_res.reg_value     = (ok && wr_eff) ? wval : 32'd0;
        o_res.next_address  = ok ? nxt : i_pc;

        o_upd.state_we   = ok;
        o_upd.next_pc    = nxt;
        o_upd.rf_we      = ok && wr_eff;
        o_upd.rf_idx     = widx;
        o_upd.rf_val     = wval;
        o_upd.hilo_we    = ok && !i_cancel && opc == OP_SPECIAL
                           && (fn == FN_MULT || fn == FN_MULTU);
        o_upd.hi_val     = (fn == FN_MULT) ? prod_s[63:32] : prod_u[63:32];
        o_upd.lo_val     = (fn == FN_MULT) ? prod_s[31:0] : prod_u[31:0];
        o_upd.br_pending = 1'b0;
        o_upd.br_target  = i_br_target;
        o_upd.cancel     = 1'b0;
        if (jump) begin
            o_upd.br_pending = 1'b1;
            o_upd.br_target  = (opc == OP_SPECIAL) ? i_vs : jtarget;
        end else if (isbr && cond) begin
            o_upd.br_pending = 1'b1;
            o_upd.br_target  = btarget;
        end else if (isbr && likely) begin
            o_upd.cancel = 1'b1;
        end
    end
endmodule

// File: hw/rtl/mips32_integer_execute_core.sv
// ============================================================================
// MIPS32 integer execute core
// Executes one instruction word per request and reports one result item.
// ============================================================================
// The result is registered on acceptance. One instruction per cycle while the
// output is not stalled; the register file, HI/LO and the fetch state are read
// and written in the same cycle as the instruction.
// Reset clears registers, HI/LO and branch state and loads the program
// counter with 0xBFC00000; no clearing pass is needed.
module mips32_integer_execute_core
    import mips_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // instr_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // instr_address, reg_write, reg_index,
                                         // reg_value, next_address, nullified,
                                         // unsupported
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data      // reset_address
);
    logic [31:0] r_pc, r_hi, r_lo, r_target;
    logic        r_pending, r_cancel, r_valid;
    t_result     r_res, n_res;
    t_update     upd;
    logic [31:0] vs, vt;
    logic        acc;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    mips_regfile u_rf (
        .i_clk, .i_rst_n,
        .i_rs (s_axis_tdata[25:21]),
        .i_rt (s_axis_tdata[20:16]),
        .o_vs (vs),
        .o_vt (vt),
        .i_we (acc && upd.rf_we),
        .i_wa (upd.rf_idx),
        .i_wd (upd.rf_val)
    );

    mips_exec u_exec (
        .i_word       (s_axis_tdata),
        .i_pc         (r_pc),
        .i_vs         (vs),
        .i_vt         (vt),
        .i_hi         (r_hi),
        .i_lo         (r_lo),
        .i_br_pending (r_pending),
        .i_br_target  (r_target),
        .i_cancel     (r_cancel),
        .o_res        (n_res),
        .o_upd        (upd)
    );

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= RESET_ADDR_DEFAULT;
            r_hi      <= '0;
            r_lo      <= '0;
            r_pending <= 1'b0;
            r_target  <= '0;
            r_cancel  <= 1'b0;
        end else if (i_cfg_valid) begin
            r_pc      <= i_cfg_data;
            r_pending <= 1'b0;
            r_cancel  <= 1'b0;
        end else if (acc) begin
            if (upd.hilo_we) begin
                r_hi <= upd.hi_val;
                r_lo <= upd.lo_val;
            end
            if (upd.state_we) begin
                r_pc      <= upd.next_pc;
                r_pending <= upd.br_pending;
                r_target  <= upd.br_target;
                r_cancel  <= upd.cancel;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_res <= n_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_res.unsupported, r_res.nullified,
                            r_res.next_address, r_res.reg_value, r_res.reg_index,
                            r_res.reg_write, r_res.instr_address};
endmodule
